[rtl/cese_pkg.sv]
// Package for the C-style escape encoder: item types, character constants
// and the escape encoding function. Depends on nothing.
package cese_pkg;

    // Input item: one raw byte of the buffer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // Result item: one character of the escaped text.
    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_run;
        logic       end_of_text;
    } t_out_item;

    // One escape sequence of up to four characters; len is 0 when absent.
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] ch;
    } t_esc;

    // Queue entry: the escape of the held byte, then the escape of the
    // final byte, and whether this transfer closed the buffer.
    typedef struct packed {
        t_esc held_esc;
        t_esc last_esc;
        logic last_byte;
    } t_entry;

    // Bytes that take a two-character escape, then the other character constants.
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_FF  = 8'h0c;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_BSL = 8'h5c;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    function automatic logic is_oct(input logic [7:0] c);
        return c inside {[8'h30:8'h37]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            return {4'h0, v} + CH_ZERO;
        end
        return {4'h0, v} + 8'd87;
    endfunction

    // Escape of byte x when it is followed by byte z (zero for none).
    function automatic t_esc esc_encode(input logic [7:0] x, input logic [7:0] z);
        t_esc       e;
        logic [7:0] c;
        e = '0;
        case (x)
            CH_BSL:  c = CH_BSL;
            CH_DQ:   c = CH_DQ;
            CH_TAB:  c = 8'h74;
            CH_LF:   c = 8'h6e;
            CH_CR:   c = 8'h72;
            CH_FF:   c = 8'h66;
            CH_BS:   c = 8'h62;
            CH_BEL:  c = 8'h61;
            CH_ESC:  c = 8'h65;
            default: c = 8'h00;
        endcase
        if (c != 8'h00) begin
            e.len   = 3'd2;
            e.ch[0] = CH_BSL;
            e.ch[1] = c;
        end else if (x inside {[PRINT_LO:PRINT_HI]}) begin
            e.len   = 3'd1;
            e.ch[0] = x;
        end else if (x < 8'd8) begin
            e.ch[0] = CH_BSL;
            if (is_oct(z)) begin
                e.len   = 3'd4;
                e.ch[1] = CH_ZERO;
                e.ch[2] = CH_ZERO;
                e.ch[3] = CH_ZERO + x;
            end else begin
                e.len   = 3'd2;
                e.ch[1] = CH_ZERO + x;
            end
        end else begin
            e.ch[0] = CH_BSL;
            e.ch[1] = CH_X;
            if (x >= 8'd16 || is_hex(z)) begin
                e.len   = 3'd4;
                e.ch[2] = hex_digit(x[7:4]);
                e.ch[3] = hex_digit(x[3:0]);
            end else begin
                e.len   = 3'd3;
                e.ch[2] = hex_digit(x[3:0]);
            end
        end
        return e;
    endfunction

endpackage

[rtl/cese_front.sv]
// Front end of the escape encoder: holds each byte until its successor
// arrives and classifies it into queue entries. Depends on cese_pkg.
module cese_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cese_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output cese_pkg::t_entry  o_entry
);
    import cese_pkg::*;

    logic [7:0] r_held_byte;
    logic       r_held_valid;
    logic [7:0] n_held_byte;
    logic       n_held_valid;
    logic       accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_entry.held_esc  = r_held_valid ? esc_encode(r_held_byte, i_in_data.data_byte) : '0;
        o_entry.last_esc  = i_in_data.last_byte ? esc_encode(i_in_data.data_byte, 8'h00)
                                                 : '0;
        o_entry.last_byte = i_in_data.last_byte;
        o_push = accept && (r_held_valid || i_in_data.last_byte);
    end

    always_comb begin
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        if (accept) begin
            n_held_byte  = i_in_data.last_byte ? 8'h00 : i_in_data.data_byte;
            n_held_valid = !i_in_data.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= 8'h00;
            r_held_valid <= 1'b0;
        end else begin
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
        end
    end

    // Nothing is queued on the opening byte of a buffer that has more to come.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_held_valid && !i_in_data.last_byte) |-> !o_push)
        else $error("entry queued without a held byte or final byte");

endmodule

[rtl/cese_fifo.sv]
// Short queue of classified entries between front and back end.
// Depends on cese_pkg.
module cese_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cese_pkg::t_entry i_entry,
    input  logic             i_pop,
    output cese_pkg::t_entry o_head,
    output logic             o_full,
    output logic             o_empty
);
    import cese_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("queue popped while empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("queue pushed while full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

[rtl/cese_back.sv]
// Back end of the escape encoder: walks the characters of the head queue entry
// one per cycle, unless the output stalls, into the output register. Depends on cese_pkg.
module cese_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cese_pkg::t_entry    i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cese_pkg::t_out_item o_out_data
);
    import cese_pkg::*;

    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       advance;
    logic [3:0] total;
    logic       final_char;
    logic [2:0] b_idx;
    logic [7:0] ch;

    assign advance    = !i_empty && (!r_out_valid || i_out_ready);
    assign total      = {1'b0, i_head.held_esc.len} + {1'b0, i_head.last_esc.len};
    assign final_char = ({1'b0, r_idx} == (total - 4'd1));
    assign b_idx      = r_idx - i_head.held_esc.len;
    assign ch         = (r_idx < i_head.held_esc.len) ? i_head.held_esc.ch[r_idx[1:0]]
                                                      : i_head.last_esc.ch[b_idx[1:0]];
    assign o_pop      = advance && final_char;

    always_comb begin
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out.out_char    = ch;
            n_out.end_of_run  = final_char;
            n_out.end_of_text = final_char && i_head.last_byte;
            n_out_valid       = 1'b1;
            n_idx             = final_char ? 3'd0 : r_idx + 3'd1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.end_of_text) |-> r_out.end_of_run)
        else $error("end of text without end of run");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> ({1'b0, r_idx} < total))
        else $error("character index beyond entry length");

endmodule

[rtl/c_escape_sequence_encoder.sv]
// Top level of the C-style escape encoder: front end, entry queue and
// back end. Depends on cese_pkg, cese_front, cese_fifo and cese_back.
//
//  Channel  Direction  Handshake                Payload
//  input    in         i_in_valid / o_in_ready  i_in_data  (t_in_item)
//  output   out        o_out_valid / i_out_ready o_out_data (t_out_item)
//
// Each input transfer yields from zero to eight characters: the escape of
// the byte held from the previous transfer, and on the final byte of a
// buffer the escape of that byte too. Characters leave one per cycle while
// the output is not stalled; each escape is one to four characters long,
// and a final byte brings two escapes. Reset is synchronous and clears
// the held byte, the queue and the output register's valid flag. The
// front end accepts a transfer in every cycle while the queue has room,
// so the input side keeps moving while the output side stalls, until
// the queue fills.
module c_escape_sequence_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cese_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cese_pkg::t_out_item o_out_data
);
    import cese_pkg::*;

    // Classified entries travel from the front end to the back end here.
    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    // The front end holds one byte back, since its escape depends on the
    // byte that follows it.
    cese_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    cese_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back end pops an entry once its last character has been loaded
    // into the output register.
    cese_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_entry),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
